@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the accumulator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ACS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("acs check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define ACS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("acs check failed");

`endif

@@ rtl/acs_pkg.sv @@
// Shared types and codes of the accumulator core.
package acs_pkg;

   typedef logic [15:0] word_type;

   // Item kinds
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_EXEC  = 2'd2;

   // Run status
   localparam logic [1:0] RUN_ACTIVE = 2'd0;
   localparam logic [1:0] RUN_HALTED = 2'd1;
   localparam logic [1:0] RUN_FAULT  = 2'd2;

   // Print events
   localparam logic [1:0] PRINT_NONE = 2'd0;
   localparam logic [1:0] PRINT_NUM  = 2'd1;
   localparam logic [1:0] PRINT_CHAR = 2'd2;

   // Opcodes
   localparam logic [3:0] OP_HLT = 4'h0;
   localparam logic [3:0] OP_LDA = 4'h1;
   localparam logic [3:0] OP_STA = 4'h2;
   localparam logic [3:0] OP_ADD = 4'h3;
   localparam logic [3:0] OP_SUB = 4'h4;
   localparam logic [3:0] OP_JMP = 4'h5;
   localparam logic [3:0] OP_CAL = 4'h6;
   localparam logic [3:0] OP_MUL = 4'h7;
   localparam logic [3:0] OP_EXT = 4'h8;
   localparam logic [3:0] OP_BRZ = 4'h9;
   localparam logic [3:0] OP_BRN = 4'hA;
   localparam logic [3:0] OP_PRT = 4'hB;
   localparam logic [3:0] OP_PRC = 4'hC;

   // Operand codes of the extended opcode
   localparam logic [11:0] EXT_RET = 12'h005;
   localparam logic [11:0] EXT_IAC = 12'h002;

   // Sign-magnitude constants
   localparam word_type SM_MINUS_ZERO = 16'h8000;

endpackage

@@ rtl/accumulator_cpu_step_core.sv @@
// Accumulator processor core: byte memory in two banks, one item per transfer.
// A 16-bit sign-magnitude accumulator machine. Each request transfer loads a
// word, starts the program at csr_start_address, or executes one instruction
// (the unused fourth kind, and an execute while the program is not running,
// change nothing), and gives one response transfer. An item goes through the
// instruction fetch read, done in the cycle of its request transfer, then the
// operand or stack read (or the store write), then execution, which loads the
// response register. The next item is taken in the execute cycle, so one item
// is taken while the last executes; the memory holds even and odd bytes in two
// single-port banks so that any big-endian word, aligned or not, is one access.
// A full response register under stall stalls the execute cycle. MEM_BYTES
// must be a power of two. The memory needs no clearing after reset.
module accumulator_cpu_step_core #(
   parameter int MEM_BYTES   = 4096,
   parameter int STACK_BYTES = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic [11:0]        req_load_address,
   input  logic [15:0]        req_load_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_run_status,
   output logic [1:0]         rsp_print_kind,
   output logic signed [15:0] rsp_print_value,
   output logic [15:0]        rsp_accumulator,
   output logic [11:0]        rsp_program_counter,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [11:0]        csr_start_address
);

   localparam int AW   = $clog2(MEM_BYTES);
   localparam int HALF = MEM_BYTES / 2;
   localparam int HW   = AW - 1;
   localparam int SPW  = $clog2(STACK_BYTES + 1);

   localparam logic [SPW-1:0] SP_STEP  = SPW'(2);
   localparam logic [SPW:0]   SP_LIMIT = (SPW + 1)'(STACK_BYTES);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DEC  = 2'd1;
   localparam logic [1:0] ST_EXE  = 2'd2;

   // Sign-magnitude to two's complement and back
   function automatic logic signed [17:0] sm_to_int(input acs_pkg::word_type w);
      logic signed [17:0] mag;
      mag = $signed({3'b000, w[14:0]});
      return w[15] ? -mag : mag;
   endfunction

   function automatic acs_pkg::word_type int_to_sm(input logic signed [17:0] v);
      logic [17:0] mag;
      mag = v[17] ? 18'(-v) : 18'(v);
      return {v[17], mag[14:0]};
   endfunction

   // Control and architectural registers
   logic [1:0]        state_ff, state_in;
   logic [11:0]       pc_ff, pc_in;
   acs_pkg::word_type acc_ff, acc_in;
   logic              nflag_ff, nflag_in;
   logic              zflag_ff, zflag_in;
   logic [SPW-1:0]    sp_ff, sp_in;
   logic [1:0]        run_ff, run_in;
   logic [11:0]       start_ff;

   // Item and instruction registers
   logic [1:0]        kind_ff;
   logic [11:0]       ld_addr_ff;
   acs_pkg::word_type ld_word_ff;
   acs_pkg::word_type ir_ff;

   // Response register
   logic              rsp_valid_ff;
   logic [1:0]        rsp_run_ff;
   logic [1:0]        rsp_pkind_ff;
   logic signed [15:0] rsp_pval_ff;
   acs_pkg::word_type rsp_acc_ff;
   logic [11:0]       rsp_pc_ff;

   // Memory banks
   logic [7:0]        even_mem [HALF];
   logic [7:0]        odd_mem  [HALF];
   logic [7:0]        even_rd_ff;
   logic [7:0]        odd_rd_ff;
   logic              swap_ff;

   logic              out_free;
   logic              exe_go;
   logic              rd_hold;
   logic              accept;
   logic [AW-1:0]     mem_addr;
   logic              mem_we;
   acs_pkg::word_type mem_wdata;
   logic [HW-1:0]     even_idx;
   logic [HW-1:0]     odd_idx;
   logic [7:0]        even_wd;
   logic [7:0]        odd_wd;
   acs_pkg::word_type rd_word;
   logic [3:0]        dec_op;
   logic [11:0]       dec_a;
   logic [3:0]        ex_op;
   logic [11:0]       ex_a;
   logic [11:0]       pc_next;
   logic              push_full;
   logic              pop_empty;
   logic signed [17:0] acc_int;
   logic signed [17:0] opnd_int;
   logic [29:0]       mul_full;
   logic              mul_neg;
   logic              set_flags;
   logic [1:0]        pkind_in;
   logic signed [15:0] pval_in;

   // Handshake
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign exe_go    = (state_ff == ST_EXE) & out_free;
   assign req_stall = ~((state_ff == ST_IDLE) | exe_go);
   assign accept    = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   // A stalled execute cycle keeps its operand in the read registers
   assign rd_hold   = (state_ff == ST_EXE) & ~exe_go;

   // Read word assembly and decode fields
   assign rd_word   = swap_ff ? {odd_rd_ff, even_rd_ff} : {even_rd_ff, odd_rd_ff};
   assign dec_op    = rd_word[15:12];
   assign dec_a     = rd_word[11:0];
   assign ex_op     = ir_ff[15:12];
   assign ex_a      = ir_ff[11:0];
   assign pc_next   = pc_ff + 12'd2;
   assign push_full = ({1'b0, sp_ff} + (SPW + 1)'(2)) > SP_LIMIT;
   assign pop_empty = sp_ff < SP_STEP;

   // Memory access select: fetch at the next pc, or the decode access
   always_comb begin
      mem_addr  = pc_in[AW-1:0];
      mem_we    = 1'b0;
      mem_wdata = acc_ff;
      if (state_ff == ST_DEC) begin
         mem_addr = dec_a[AW-1:0];
         case (kind_ff)
            acs_pkg::KIND_LOAD: begin
               mem_addr  = ld_addr_ff[AW-1:0];
               mem_we    = 1'b1;
               mem_wdata = ld_word_ff;
            end
            acs_pkg::KIND_EXEC: begin
               if (run_ff == acs_pkg::RUN_ACTIVE) begin
                  case (dec_op)
                     acs_pkg::OP_STA: mem_we = 1'b1;
                     acs_pkg::OP_CAL: begin
                        mem_addr  = AW'(sp_ff);
                        mem_we    = ~push_full;
                        mem_wdata = {4'h0, pc_next};
                     end
                     acs_pkg::OP_EXT: begin
                        if (dec_a == acs_pkg::EXT_RET) begin
                           mem_addr = AW'(sp_ff - SP_STEP);
                        end
                     end
                     default: ;
                  endcase
               end
            end
            default: ;
         endcase
      end
   end

   // Byte lanes: an odd address puts the high byte in the odd bank
   assign odd_idx  = mem_addr[AW-1:1];
   assign even_idx = mem_addr[AW-1:1] + HW'(mem_addr[0]);
   assign even_wd  = mem_addr[0] ? mem_wdata[7:0] : mem_wdata[15:8];
   assign odd_wd   = mem_addr[0] ? mem_wdata[15:8] : mem_wdata[7:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         even_mem[even_idx] <= even_wd;
      end
      if (!rd_hold) begin
         even_rd_ff <= even_mem[even_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         odd_mem[odd_idx] <= odd_wd;
      end
      if (!rd_hold) begin
         odd_rd_ff <= odd_mem[odd_idx];
         swap_ff   <= mem_addr[0];
      end
   end

   // Execute datapath
   assign acc_int  = sm_to_int(acc_ff);
   assign opnd_int = sm_to_int(rd_word);
   assign mul_full = acc_ff[14:0] * rd_word[14:0];
   assign mul_neg  = (acc_ff[15] ^ rd_word[15]) & (|acc_ff[14:0]) & (|rd_word[14:0]);

   always_comb begin
      pc_in     = pc_ff;
      acc_in    = acc_ff;
      nflag_in  = nflag_ff;
      zflag_in  = zflag_ff;
      sp_in     = sp_ff;
      run_in    = run_ff;
      pkind_in  = acs_pkg::PRINT_NONE;
      pval_in   = 16'sd0;
      set_flags = 1'b0;
      if (state_ff == ST_EXE) begin
         case (kind_ff)
            acs_pkg::KIND_START: begin
               pc_in    = start_ff;
               nflag_in = 1'b0;
               zflag_in = 1'b0;
               run_in   = acs_pkg::RUN_ACTIVE;
            end
            acs_pkg::KIND_EXEC: begin
               if (run_ff == acs_pkg::RUN_ACTIVE) begin
                  pc_in = pc_next;
                  case (ex_op)
                     acs_pkg::OP_HLT: run_in = acs_pkg::RUN_HALTED;
                     acs_pkg::OP_LDA: begin
                        acc_in    = rd_word;
                        set_flags = 1'b1;
                     end
                     acs_pkg::OP_ADD: begin
                        acc_in    = int_to_sm(acc_int + opnd_int);
                        set_flags = 1'b1;
                     end
                     acs_pkg::OP_SUB: begin
                        acc_in    = int_to_sm(acc_int - opnd_int);
                        set_flags = 1'b1;
                     end
                     acs_pkg::OP_JMP: pc_in = ex_a;
                     acs_pkg::OP_CAL: begin
                        if (push_full) begin
                           run_in = acs_pkg::RUN_FAULT;
                        end else begin
                           sp_in = sp_ff + SP_STEP;
                           pc_in = ex_a;
                        end
                     end
                     acs_pkg::OP_MUL: begin
                        acc_in    = {mul_neg, mul_full[14:0]};
                        set_flags = 1'b1;
                     end
                     acs_pkg::OP_EXT: begin
                        if (ex_a == acs_pkg::EXT_RET) begin
                           if (pop_empty) begin
                              run_in = acs_pkg::RUN_FAULT;
                           end else begin
                              sp_in = sp_ff - SP_STEP;
                              pc_in = rd_word[11:0];
                           end
                        end else if (ex_a == acs_pkg::EXT_IAC) begin
                           acc_in = int_to_sm(acc_int + 18'sd1);
                        end else begin
                           run_in = acs_pkg::RUN_HALTED;
                        end
                     end
                     acs_pkg::OP_BRZ: begin
                        if (zflag_ff) begin
                           pc_in = ex_a;
                        end
                     end
                     acs_pkg::OP_BRN: begin
                        if (nflag_ff) begin
                           pc_in = ex_a;
                        end
                     end
                     acs_pkg::OP_PRT: begin
                        pkind_in = acs_pkg::PRINT_NUM;
                        pval_in  = $signed(opnd_int[15:0]);
                     end
                     acs_pkg::OP_PRC: begin
                        pkind_in = acs_pkg::PRINT_CHAR;
                        pval_in  = $signed({8'h00, ex_a[7:0]});
                     end
                     default: ;
                  endcase
                  if (set_flags) begin
                     nflag_in = acc_in > acs_pkg::SM_MINUS_ZERO;
                     zflag_in = acc_in == 16'h0000;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DEC;
            end
         end
         ST_DEC: state_in = ST_EXE;
         ST_EXE: begin
            if (exe_go) begin
               state_in = accept ? ST_DEC : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= 12'd0;
         acc_ff       <= 16'h0000;
         nflag_ff     <= 1'b0;
         zflag_ff     <= 1'b0;
         sp_ff        <= '0;
         run_ff       <= acs_pkg::RUN_HALTED;
         start_ff     <= 12'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            start_ff <= csr_start_address;
         end
         if (exe_go) begin
            pc_ff    <= pc_in;
            acc_ff   <= acc_in;
            nflag_ff <= nflag_in;
            zflag_ff <= zflag_in;
            sp_ff    <= sp_in;
            run_ff   <= run_in;
         end
         if (exe_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Item, instruction and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff    <= req_kind;
         ld_addr_ff <= req_load_address;
         ld_word_ff <= req_load_word;
      end
      if (state_ff == ST_DEC) begin
         ir_ff <= rd_word;
      end
      if (exe_go) begin
         rsp_run_ff   <= run_in;
         rsp_pkind_ff <= pkind_in;
         rsp_pval_ff  <= pval_in;
         rsp_acc_ff   <= acc_in;
         rsp_pc_ff    <= pc_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_run_status      = rsp_run_ff;
   assign rsp_print_kind      = rsp_pkind_ff;
   assign rsp_print_value     = rsp_pval_ff;
   assign rsp_accumulator     = rsp_acc_ff;
   assign rsp_program_counter = rsp_pc_ff;

endmodule

@@ rtl/acs_checker.sv @@
// Port checker for the accumulator core, bound to its top level.
`include "assert_macros.svh"

module acs_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [1:0]         rsp_run_status,
   input logic [1:0]         rsp_print_kind,
   input logic signed [15:0] rsp_print_value,
   input logic [15:0]        rsp_accumulator,
   input logic [11:0]        rsp_program_counter
);

   // A stalled response holds
   `ACS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_accumulator) && $stable(rsp_program_counter) && $stable(rsp_run_status))

   // A response without a print carries a zero value
   `ACS_ASSERT_IMPLY(a_quiet_value, clock, reset, rsp_valid && rsp_print_kind == acs_pkg::PRINT_NONE, rsp_print_value == 16'sd0)

   // Prints only come from instructions that keep the program running
   `ACS_ASSERT_IMPLY(a_print_running, clock, reset, rsp_valid && rsp_print_kind != acs_pkg::PRINT_NONE, rsp_run_status == acs_pkg::RUN_ACTIVE)

   // Character prints carry one byte
   `ACS_ASSERT_IMPLY(a_char_byte, clock, reset, rsp_valid && rsp_print_kind == acs_pkg::PRINT_CHAR, rsp_print_value[15:8] == 8'h00)

endmodule

bind accumulator_cpu_step_core acs_checker u_acs_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_run_status      (rsp_run_status),
   .rsp_print_kind      (rsp_print_kind),
   .rsp_print_value     (rsp_print_value),
   .rsp_accumulator     (rsp_accumulator),
   .rsp_program_counter (rsp_program_counter)
);

@@ tb/sv/tb_accumulator_cpu_step_core.sv @@
// Self-checking testbench of the accumulator processor core with random programs and stalls.
module tb_accumulator_cpu_step_core;

   localparam int          STACK_BYTES  = 256;
   localparam int          ITEM_TARGET  = 1900;
   localparam int          CYCLE_LIMIT  = 1000000;
   localparam int          REPORT_LIMIT = 100;
   localparam logic [1:0]  KIND_SPARE   = 2'd3;
   localparam logic [3:0]  OP_PRS       = 4'hD;

   typedef struct packed {
      logic [1:0]  kind;
      logic [11:0] address;
      logic [15:0] word;
   } request_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  pkind;
      logic [15:0] pval;
      logic [15:0] acc;
      logic [11:0] pc;
   } step_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_kind = '0;
   logic [11:0]        req_load_address = '0;
   logic [15:0]        req_load_word = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_run_status;
   logic [1:0]         rsp_print_kind;
   logic signed [15:0] rsp_print_value;
   logic [15:0]        rsp_accumulator;
   logic [11:0]        rsp_program_counter;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [11:0]        csr_start_address = '0;

   accumulator_cpu_step_core #(
      .MEM_BYTES   (4096),
      .STACK_BYTES (STACK_BYTES)
   ) DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_load_address    (req_load_address),
      .req_load_word       (req_load_word),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_run_status      (rsp_run_status),
      .rsp_print_kind      (rsp_print_kind),
      .rsp_print_value     (rsp_print_value),
      .rsp_accumulator     (rsp_accumulator),
      .rsp_program_counter (rsp_program_counter),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_start_address   (csr_start_address)
   );

   always #10 clock = ~clock;

   // Shadow machine state, advanced in transfer order as requests are queued
   logic [7:0]  shadow_mem [0:4095];
   bit          shadow_written [0:4095];
   logic [11:0] shadow_pc = '0;
   logic [15:0] shadow_acc = '0;
   bit          shadow_neg = 1'b0;
   bit          shadow_zero = 1'b0;
   int          shadow_sp = 0;
   logic [1:0]  shadow_status = acs_pkg::RUN_HALTED;
   logic [11:0] shadow_start = '0;

   request_type     pending_items [$];
   step_result_type predicted_results [$];

   int mismatch_count = 0;
   int responses_checked = 0;
   int items_queued = 0;
   int instructions_run = 0;
   int prints_predicted = 0;
   int faults_predicted = 0;
   int settings_used = 0;
   int programs_run = 0;
   int cycle_count = 0;

   // Memory access with byte addresses wrapping at the top
   function automatic logic [15:0] fetch_word(logic [11:0] addr);
      logic [11:0] nxt;
      nxt = addr + 12'd1;
      return {shadow_mem[addr], shadow_mem[nxt]};
   endfunction

   function automatic void store_word(logic [11:0] addr, logic [15:0] value);
      logic [11:0] nxt;
      nxt = addr + 12'd1;
      shadow_mem[addr] = value[15:8];
      shadow_mem[nxt] = value[7:0];
      shadow_written[addr] = 1'b1;
      shadow_written[nxt] = 1'b1;
   endfunction

   // Sign-magnitude conversion; magnitude kept modulo 32768
   function automatic int from_sm(logic [15:0] w);
      int mag;
      mag = int'(w[14:0]);
      return w[15] ? -mag : mag;
   endfunction

   function automatic logic [15:0] to_sm(int v);
      int mag;
      mag = (v < 0) ? -v : v;
      return {(v < 0) ? 1'b1 : 1'b0, mag[14:0]};
   endfunction

   function automatic void update_flags();
      shadow_neg = (shadow_acc > acs_pkg::SM_MINUS_ZERO);
      shadow_zero = (shadow_acc == 16'h0000);
   endfunction

   function automatic void stack_fault();
      shadow_status = acs_pkg::RUN_FAULT;
      faults_predicted++;
   endfunction

   // Advance the shadow machine by one request and give the response it causes
   function automatic step_result_type predict_step(request_type r);
      step_result_type res;
      logic [15:0]     ir;
      logic [15:0]     popped;
      logic [11:0]     a;
      int              printed;
      res.pkind = acs_pkg::PRINT_NONE;
      res.pval = '0;
      case (r.kind)
         acs_pkg::KIND_LOAD: store_word(r.address, r.word);
         acs_pkg::KIND_START: begin
            shadow_pc = shadow_start;
            shadow_neg = 1'b0;
            shadow_zero = 1'b0;
            shadow_status = acs_pkg::RUN_ACTIVE;
         end
         acs_pkg::KIND_EXEC: if (shadow_status == acs_pkg::RUN_ACTIVE) begin
            instructions_run++;
            ir = fetch_word(shadow_pc);
            a = ir[11:0];
            shadow_pc = shadow_pc + 12'd2;
            case (ir[15:12])
               acs_pkg::OP_HLT: shadow_status = acs_pkg::RUN_HALTED;
               acs_pkg::OP_LDA: begin
                  shadow_acc = fetch_word(a);
                  update_flags();
               end
               acs_pkg::OP_STA: store_word(a, shadow_acc);
               acs_pkg::OP_ADD: begin
                  shadow_acc = to_sm(from_sm(shadow_acc) + from_sm(fetch_word(a)));
                  update_flags();
               end
               acs_pkg::OP_SUB: begin
                  shadow_acc = to_sm(from_sm(shadow_acc) - from_sm(fetch_word(a)));
                  update_flags();
               end
               acs_pkg::OP_JMP: shadow_pc = a;
               acs_pkg::OP_CAL: begin
                  if (shadow_sp + 2 > STACK_BYTES) begin
                     stack_fault();
                  end else begin
                     store_word(12'(shadow_sp), {4'h0, shadow_pc});
                     shadow_sp += 2;
                     shadow_pc = a;
                  end
               end
               acs_pkg::OP_MUL: begin
                  shadow_acc = to_sm(from_sm(shadow_acc) * from_sm(fetch_word(a)));
                  update_flags();
               end
               acs_pkg::OP_EXT: begin
                  if (a == acs_pkg::EXT_RET) begin
                     if (shadow_sp < 2) begin
                        stack_fault();
                     end else begin
                        shadow_sp -= 2;
                        popped = fetch_word(12'(shadow_sp));
                        shadow_pc = popped[11:0];
                     end
                  end else if (a == acs_pkg::EXT_IAC) begin
                     shadow_acc = to_sm(from_sm(shadow_acc) + 1);
                  end else begin
                     shadow_status = acs_pkg::RUN_HALTED;
                  end
               end
               acs_pkg::OP_BRZ: if (shadow_zero) shadow_pc = a;
               acs_pkg::OP_BRN: if (shadow_neg) shadow_pc = a;
               acs_pkg::OP_PRT: begin
                  printed = from_sm(fetch_word(a));
                  res.pkind = acs_pkg::PRINT_NUM;
                  res.pval = printed[15:0];
                  prints_predicted++;
               end
               acs_pkg::OP_PRC: begin
                  res.pkind = acs_pkg::PRINT_CHAR;
                  res.pval = {8'h00, a[7:0]};
                  prints_predicted++;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      res.status = shadow_status;
      res.acc = shadow_acc;
      res.pc = shadow_pc;
      return res;
   endfunction

   // Queue one request together with the response it must produce
   function automatic void send(logic [1:0] kind, logic [11:0] address, logic [15:0] word);
      request_type r;
      r.kind = kind;
      r.address = address;
      r.word = word;
      pending_items.push_back(r);
      predicted_results.push_back(predict_step(r));
      if (kind != KIND_SPARE) items_queued++;
   endfunction

   function automatic void queue_start();
      send(acs_pkg::KIND_START, 12'($urandom_range(0, 4095)), 16'($urandom_range(0, 65535)));
   endfunction

   // Operand-heavy words, biased to signs, extremes and minus zero
   function automatic logic [15:0] random_data();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return acs_pkg::SM_MINUS_ZERO;
         2: return 16'h7FFF;
         3: return 16'hFFFF;
         4: return 16'h0001;
         5: return {$urandom_range(0, 1) != 0, 15'($urandom_range(0, 20))};
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // Instruction with operands mostly inside the program's code and data areas
   function automatic logic [15:0] random_instruction(logic [11:0] base, int len,
                                                      logic [11:0] data_base);
      int unsigned roll;
      int unsigned ext_roll;
      logic [11:0] data_addr;
      logic [11:0] code_addr;
      logic [11:0] any_addr;
      any_addr = 12'($urandom_range(0, 4095));
      data_addr = ($urandom_range(0, 99) < 85) ?
                  data_base + 12'(2 * $urandom_range(0, 7)) : any_addr;
      code_addr = ($urandom_range(0, 99) < 85) ?
                  base + 12'(2 * $urandom_range(0, len - 1)) : any_addr;
      roll = $urandom_range(0, 99);
      if (roll < 4) return {acs_pkg::OP_HLT, any_addr};
      else if (roll < 14) return {acs_pkg::OP_LDA, data_addr};
      else if (roll < 22) return {acs_pkg::OP_STA, data_addr};
      else if (roll < 32) return {acs_pkg::OP_ADD, data_addr};
      else if (roll < 40) return {acs_pkg::OP_SUB, data_addr};
      else if (roll < 44) return {acs_pkg::OP_JMP, code_addr};
      else if (roll < 50) return {acs_pkg::OP_CAL, code_addr};
      else if (roll < 56) return {acs_pkg::OP_MUL, data_addr};
      else if (roll < 64) begin
         ext_roll = $urandom_range(0, 9);
         return {acs_pkg::OP_EXT, (ext_roll < 5) ? acs_pkg::EXT_RET :
                                  (ext_roll < 9) ? acs_pkg::EXT_IAC : any_addr};
      end
      else if (roll < 71) return {acs_pkg::OP_BRZ, code_addr};
      else if (roll < 78) return {acs_pkg::OP_BRN, code_addr};
      else if (roll < 84) return {acs_pkg::OP_PRT, data_addr};
      else if (roll < 90) return {acs_pkg::OP_PRC, any_addr};
      else return {OP_PRS + 4'($urandom_range(0, 2)), any_addr};
   endfunction

   // Next execute would read a byte never written: report where to load first
   function automatic bit find_unwritten_read(output logic [11:0] hole, output bit for_fetch);
      logic [15:0] ir;
      logic [11:0] next_byte;
      bit          reads_operand;
      hole = '0;
      for_fetch = 1'b0;
      if (shadow_status != acs_pkg::RUN_ACTIVE) return 1'b0;
      next_byte = shadow_pc + 12'd1;
      for_fetch = 1'b1;
      if (!shadow_written[shadow_pc]) begin
         hole = shadow_pc;
         return 1'b1;
      end
      if (!shadow_written[next_byte]) begin
         hole = next_byte;
         return 1'b1;
      end
      for_fetch = 1'b0;
      ir = fetch_word(shadow_pc);
      case (ir[15:12])
         acs_pkg::OP_LDA, acs_pkg::OP_ADD, acs_pkg::OP_SUB,
         acs_pkg::OP_MUL, acs_pkg::OP_PRT: reads_operand = 1'b1;
         default: reads_operand = 1'b0;
      endcase
      if (!reads_operand) return 1'b0;
      next_byte = ir[11:0] + 12'd1;
      if (!shadow_written[ir[11:0]]) begin
         hole = ir[11:0];
         return 1'b1;
      end
      if (!shadow_written[next_byte]) begin
         hole = next_byte;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void queue_exec();
      logic [11:0] hole;
      bit          for_fetch;
      while (find_unwritten_read(hole, for_fetch))
         send(acs_pkg::KIND_LOAD, hole,
              for_fetch ? random_instruction(hole, 4, hole + 12'h040) : random_data());
      send(acs_pkg::KIND_EXEC, 12'($urandom_range(0, 4095)), 16'($urandom_range(0, 65535)));
   endfunction

   // Idle length: mostly none or short, a few long, with calm stretches of none
   function automatic int unsigned idle_length(inout int unsigned calm);
      int unsigned roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 99) < 3) calm = $urandom_range(40, 150);
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(15, 30);
   endfunction

   // Request driver: next item once the current one transfers
   int unsigned send_gap = 0;
   int unsigned send_calm = 0;
   request_type next_req;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            next_req = pending_items.pop_front();
            req_kind <= next_req.kind;
            req_load_address <= next_req.address;
            req_load_word <= next_req.word;
            req_valid <= 1'b1;
            send_gap = idle_length(send_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   function automatic void check_field(string label, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch: expected %h, actual %h", $time, label, want, got);
      end
   endfunction

   // Response monitor and random stall
   int unsigned     stall_left = 0;
   int unsigned     open_left = 0;
   int unsigned     recv_calm = 0;
   step_result_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            responses_checked++;
            if (predicted_results.size() == 0) begin
               mismatch_count++;
               $display("%0t: response with none pending: expected nothing, actual pc %h",
                        $time, rsp_program_counter);
            end else begin
               want = predicted_results.pop_front();
               check_field("run_status", 16'(want.status), 16'(rsp_run_status));
               check_field("print_kind", 16'(want.pkind), 16'(rsp_print_kind));
               check_field("print_value", want.pval, rsp_print_value);
               check_field("accumulator", want.acc, rsp_accumulator);
               check_field("program_counter", 16'(want.pc), 16'(rsp_program_counter));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (open_left > 0) begin
               open_left--;
            end else begin
               stall_left = idle_length(recv_calm);
               open_left = $urandom_range(0, 4);
            end
         end
      end
   end

   // Run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses pending",
                  cycle_count, predicted_results.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Wait until every queued request has transferred and every response has come
   task automatic drain();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || predicted_results.size() != 0);
      repeat (6) @(negedge clock);
   endtask

   task automatic set_start_address(logic [11:0] value);
      drain();
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_start_address <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      shadow_start = value;
      settings_used++;
   endtask

   // Stimulus: directed opening, then random programs per phase
   initial begin
      int          phase;
      int          len;
      int          runs;
      int unsigned roll;
      bit          storm;
      logic [11:0] base;
      logic [11:0] data_base;
      logic [11:0] loop_pc;
      phase = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      set_start_address(12'h000);

      // Execute while halted, ignored kind, return with an empty stack
      queue_exec();
      send(KIND_SPARE, 12'hFFF, 16'hFFFF);
      send(acs_pkg::KIND_LOAD, 12'h000, {acs_pkg::OP_EXT, acs_pkg::EXT_RET});
      queue_start();
      queue_exec();
      queue_exec();
      // Word at the top address wraps into byte 0; add overflows; print the extreme
      send(acs_pkg::KIND_LOAD, 12'hFFF, 16'h7FFF);
      send(acs_pkg::KIND_LOAD, 12'h002, {acs_pkg::OP_LDA, 12'hFFF});
      send(acs_pkg::KIND_LOAD, 12'h004, {acs_pkg::OP_ADD, 12'h00A});
      send(acs_pkg::KIND_LOAD, 12'h00A, 16'h0001);
      send(acs_pkg::KIND_LOAD, 12'h006, {acs_pkg::OP_SUB, 12'h00C});
      send(acs_pkg::KIND_LOAD, 12'h00C, 16'hFFFF);
      send(acs_pkg::KIND_LOAD, 12'h008, {acs_pkg::OP_PRT, 12'h00C});
      queue_start();
      repeat (7) queue_exec();

      while (items_queued < ITEM_TARGET) begin
         storm = (phase == 6 || phase == 24);
         if (storm) set_start_address(12'($urandom_range(1024, 2046) * 2));
         else if (phase == 0) set_start_address(12'hFFF);
         else if (phase == 4) set_start_address(12'h000);
         else if (phase % 4 == 0) set_start_address(12'($urandom_range(0, 4095)));

         if (storm) begin
            // Self-call until the stack overflows, then unwind until it underflows
            queue_start();
            loop_pc = shadow_pc;
            send(acs_pkg::KIND_LOAD, loop_pc, {acs_pkg::OP_CAL, loop_pc});
            for (int i = 0; i < 140 && shadow_status == acs_pkg::RUN_ACTIVE; i++)
               queue_exec();
            send(acs_pkg::KIND_LOAD, loop_pc, {acs_pkg::OP_EXT, acs_pkg::EXT_RET});
            send(acs_pkg::KIND_LOAD, loop_pc + 12'd2, {acs_pkg::OP_EXT, acs_pkg::EXT_RET});
            queue_start();
            for (int i = 0; i < 140 && shadow_status == acs_pkg::RUN_ACTIVE; i++)
               queue_exec();
         end else begin
            base = shadow_start;
            len = $urandom_range(4, 12);
            data_base = 12'($urandom_range(0, 4095));
            for (int i = 0; i < len; i++)
               send(acs_pkg::KIND_LOAD, base + 12'(2 * i),
                    random_instruction(base, len, data_base));
            for (int k = 0; k < 8; k++)
               send(acs_pkg::KIND_LOAD, data_base + 12'(2 * k), random_data());
            queue_start();
            programs_run++;
            runs = $urandom_range(8, 50);
            for (int i = 0; i < runs; i++) begin
               roll = $urandom_range(0, 99);
               if (roll < 5)
                  send(acs_pkg::KIND_LOAD, 12'($urandom_range(0, 4095)),
                       16'($urandom_range(0, 65535)));
               else if (roll < 7)
                  send(KIND_SPARE, 12'($urandom_range(0, 4095)), 16'($urandom_range(0, 65535)));
               else if (roll < 9)
                  queue_start();
               queue_exec();
               if (shadow_status != acs_pkg::RUN_ACTIVE && $urandom_range(0, 3) != 0) break;
            end
         end
         phase++;
      end

      drain();
      $display("Covered %0d requests, %0d instructions executed, %0d programs, %0d start addresses",
               items_queued, instructions_run, programs_run, settings_used);
      $display("Checked %0d responses, including %0d prints and %0d stack faults",
               responses_checked, prints_predicted, faults_predicted);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/acs_pkg.sv
rtl/accumulator_cpu_step_core.sv
rtl/acs_checker.sv
tb/sv/tb_accumulator_cpu_step_core.sv
